[sv/time_of_day_alu_core_macros.svh]
// Assertion macros shared by the time-of-day ALU checker.
`ifndef TIME_OF_DAY_ALU_CORE_MACROS_SVH
`define TIME_OF_DAY_ALU_CORE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define TOD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TOD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tod_pkg.sv]
// Types and constants of the time-of-day ALU.
`default_nettype none

package tod_pkg;

	// Operation selector
	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_SUB     = 3'd1,
		CMD_LESS    = 3'd2,
		CMD_WINDOW  = 3'd3,
		CMD_NEAREST = 3'd4
	} cmd_t;

	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	// Beat between the evaluate stage and the split stage
	typedef struct packed {
		logic        valid;
		logic [16:0] secs;
		logic        flag;
	} tod_mid_t;

endpackage

`default_nettype wire

[sv/tod_in_if.sv]
// Request channel: operation and three times of day.
`default_nettype none

interface tod_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [4:0] a_hours;
	logic [5:0] a_minutes;
	logic [5:0] a_seconds;
	logic [4:0] b_hours;
	logic [5:0] b_minutes;
	logic [5:0] b_seconds;
	logic [4:0] c_hours;
	logic [5:0] c_minutes;
	logic [5:0] c_seconds;
	logic signed [7:0] delta_seconds;

	modport source (
		output valid, cmd, a_hours, a_minutes, a_seconds, b_hours, b_minutes, b_seconds,
			c_hours, c_minutes, c_seconds, delta_seconds,
		input  ready
	);
	modport sink (
		input  valid, cmd, a_hours, a_minutes, a_seconds, b_hours, b_minutes, b_seconds,
			c_hours, c_minutes, c_seconds, delta_seconds,
		output ready
	);
	modport mon (
		input valid, ready, cmd, a_hours, a_minutes, a_seconds, b_hours, b_minutes,
			b_seconds, c_hours, c_minutes, c_seconds, delta_seconds
	);
endinterface

`default_nettype wire

[sv/tod_out_if.sv]
// Result channel: time of day and flag.
`default_nettype none

interface tod_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] out_hours;
	logic [5:0] out_minutes;
	logic [5:0] out_seconds;
	logic       flag;

	modport source (
		output valid, out_hours, out_minutes, out_seconds, flag,
		input  ready
	);
	modport sink (
		input  valid, out_hours, out_minutes, out_seconds, flag,
		output ready
	);
	modport mon (
		input valid, ready, out_hours, out_minutes, out_seconds, flag
	);
endinterface

`default_nettype wire

[sv/tod_eval.sv]
// Input register and evaluate stage: day seconds for add/subtract, flag for compares.
`default_nettype none

module tod_eval import tod_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tod_in_if.sink   req,
	output tod_mid_t mid,
	input  logic     mid_ready
);

	// Raw h/m/s to seconds, folded once into one day
	function automatic logic [16:0] day_secs(input logic [4:0] h, input logic [5:0] m,
		input logic [5:0] s);
		logic [16:0] raw;
		raw = ({12'b0, h} << 12) - ({12'b0, h} << 9) + ({12'b0, h} << 4)
			+ ({11'b0, m} << 6) - ({11'b0, m} << 2) + {11'b0, s};
		if (raw >= SECS_PER_DAY) begin
			raw = raw - SECS_PER_DAY;
		end
		return raw;
	endfunction

	// Inclusive window test, wrapping past midnight when hi precedes lo
	function automatic logic in_window(input logic [16:0] t, input logic [16:0] lo,
		input logic [16:0] hi);
		logic res;
		if (lo < hi) begin
			res = (t >= lo) && (t <= hi);
		end else if (hi < lo) begin
			res = (t >= lo) || (t <= hi);
		end else begin
			res = (t == lo);
		end
		return res;
	endfunction

	logic        v_s1;
	logic [2:0]  cmd_s1;
	logic [4:0]  ah_s1, bh_s1, ch_s1;
	logic [5:0]  am_s1, as_s1, bm_s1, bs_s1, cm_s1, cs_s1;
	logic [7:0]  delta_s1;

	logic        v_s2;
	logic [16:0] secs_s2;
	logic        flag_s2;

	logic        en_s1, en_s2;
	logic [16:0] ta, tb, ka, kb, kc;
	logic [17:0] sum, diff;
	logic [16:0] secs_d;
	logic        flag_d, fwd, back;

	assign en_s2     = !v_s2 || mid_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// Stage 1: capture request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			cmd_s1   <= req.cmd;
			ah_s1    <= req.a_hours;
			am_s1    <= req.a_minutes;
			as_s1    <= req.a_seconds;
			bh_s1    <= req.b_hours;
			bm_s1    <= req.b_minutes;
			bs_s1    <= req.b_seconds;
			ch_s1    <= req.c_hours;
			cm_s1    <= req.c_minutes;
			cs_s1    <= req.c_seconds;
			delta_s1 <= req.delta_seconds;
		end
	end

	// Operands: seconds for arithmetic, packed keys for ordering
	assign ta = day_secs(ah_s1, am_s1, as_s1);
	assign tb = day_secs(bh_s1, bm_s1, bs_s1);
	assign ka = {ah_s1, am_s1, as_s1};
	assign kb = {bh_s1, bm_s1, bs_s1};
	assign kc = {ch_s1, cm_s1, cs_s1};

	assign sum  = {1'b0, ta} + {{10{delta_s1[7]}}, delta_s1};
	assign diff = {1'b0, ta} - {1'b0, tb};

	assign fwd  = in_window(ka, kb, kc);
	assign back = in_window(ka, kc, kb);

	// Operation decode
	always_comb begin
		secs_d = '0;
		flag_d = 1'b0;
		unique case (cmd_t'(cmd_s1))
			CMD_ADD: begin
				if (sum[17]) begin
					secs_d = sum[16:0] + SECS_PER_DAY;
				end else if (sum[16:0] >= SECS_PER_DAY) begin
					secs_d = sum[16:0] - SECS_PER_DAY;
				end else begin
					secs_d = sum[16:0];
				end
			end
			CMD_SUB: begin
				secs_d = diff[17] ? (diff[16:0] + SECS_PER_DAY) : diff[16:0];
			end
			CMD_LESS:    flag_d = (ka < kb);
			CMD_WINDOW:  flag_d = fwd;
			CMD_NEAREST: flag_d = back && (!fwd || (ka == kc));
			default: begin
				secs_d = '0;
				flag_d = 1'b0;
			end
		endcase
	end

	// Stage 2: evaluated beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			secs_s2 <= secs_d;
			flag_s2 <= flag_d;
		end
	end

	assign mid.valid = v_s2;
	assign mid.secs  = secs_s2;
	assign mid.flag  = flag_s2;

endmodule

`default_nettype wire

[sv/tod_split.sv]
// Split stages: day seconds into hours, then minutes and seconds.
`default_nettype none

module tod_split import tod_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tod_mid_t  mid,
	output logic      mid_ready,
	tod_out_if.source rsp
);

	// Reciprocals: floor(t/3600) for t < 86400, floor(r/60) for r < 3600
	localparam logic [34:0] HOUR_RECIP = 35'd149131;
	localparam logic [24:0] MIN_RECIP  = 25'd4370;

	logic        en_s3, en_s4;
	logic        v_s3, flag_s3;
	logic [4:0]  hrs_s3;
	logic [11:0] rem_s3;

	logic        v_s4, flag_s4;
	logic [4:0]  hrs_s4;
	logic [5:0]  min_s4, sec_s4;

	logic [34:0] prod_h;
	logic [4:0]  hrs_d;
	logic [16:0] h3600, rem_full;
	logic [24:0] prod_m;
	logic [5:0]  min_d;
	logic [11:0] m60, sec_full;

	assign en_s4     = !v_s4 || rsp.ready;
	assign en_s3     = !v_s3 || en_s4;
	assign mid_ready = en_s3;

	// Hours and remainder within the hour
	assign prod_h   = {18'b0, mid.secs} * HOUR_RECIP;
	assign hrs_d    = prod_h[33:29];
	assign h3600    = ({12'b0, hrs_d} << 12) - ({12'b0, hrs_d} << 9) + ({12'b0, hrs_d} << 4);
	assign rem_full = mid.secs - h3600;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= mid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && mid.valid) begin
			hrs_s3  <= hrs_d;
			rem_s3  <= rem_full[11:0];
			flag_s3 <= mid.flag;
		end
	end

	// Minutes and seconds
	assign prod_m   = {13'b0, rem_s3} * MIN_RECIP;
	assign min_d    = prod_m[23:18];
	assign m60      = ({6'b0, min_d} << 6) - ({6'b0, min_d} << 2);
	assign sec_full = rem_s3 - m60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			hrs_s4  <= hrs_s3;
			min_s4  <= min_d;
			sec_s4  <= sec_full[5:0];
			flag_s4 <= flag_s3;
		end
	end

	assign rsp.valid       = v_s4;
	assign rsp.out_hours   = hrs_s4;
	assign rsp.out_minutes = min_s4;
	assign rsp.out_seconds = sec_s4;
	assign rsp.flag        = flag_s4;

endmodule

`default_nettype wire

[sv/time_of_day_alu_core.sv]
// Request beat to result beat: input, evaluate, hours, min/sec register stages in order.
// Throughput: one beat per cycle unless stalled; a stage moves if empty or the next moves.
// A stall holds the last stage and full ones behind it; empty stages keep taking beats.
// Reset (arst_n low, asynchronous) clears all stage valid bits; no result is pending.
// Top level of the time-of-day ALU.
`default_nettype none

module time_of_day_alu_core import tod_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tod_in_if.sink    req,
	tod_out_if.source rsp
);

	tod_mid_t mid;
	logic     mid_ready;

	tod_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mid       (mid),
		.mid_ready (mid_ready)
	);

	tod_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (mid),
		.mid_ready (mid_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[sv/tod_checker.sv]
// Port-level checks of the time-of-day ALU, bound to the top level.
`default_nettype none
`include "time_of_day_alu_core_macros.svh"

module tod_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [4:0] out_hours,
	input logic [5:0] out_minutes,
	input logic [5:0] out_seconds,
	input logic       flag
);

	logic [17:0] rsp_beat;
	logic        tod_legal;
	logic        tod_zero;

	assign rsp_beat  = {out_hours, out_minutes, out_seconds, flag};
	assign tod_legal = (out_hours <= 5'd23) && (out_minutes <= 6'd59) && (out_seconds <= 6'd59);
	assign tod_zero  = (out_hours == 5'd0) && (out_minutes == 6'd0) && (out_seconds == 6'd0);

	// Result beat held while stalled
	`TOD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat), "result beat changed while stalled")

	// Every time result is a legal time of day
	`TOD_ASSERT_IMPL(a_rsp_range, clk, arst_n, rsp_valid, tod_legal, "result time out of range")

	// A set flag comes only from a compare, whose time fields are zero
	`TOD_ASSERT_IMPL(a_flag_zero, clk, arst_n, rsp_valid && flag, tod_zero, "flag set with nonzero time")

	// Request side never blocks while the result side is free to drain
	`TOD_ASSERT_IMPL(a_req_ready, clk, arst_n, rsp_ready, req_ready, "request stalled")

endmodule

bind time_of_day_alu_core tod_checker u_tod_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_hours   (rsp.out_hours),
	.out_minutes (rsp.out_minutes),
	.out_seconds (rsp.out_seconds),
	.flag        (rsp.flag)
);

`default_nettype wire
